// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/gvp_pkg.sv -----
// Types and constants of the galvo voltage to position block.
package gvp_pkg;

	localparam int VOLT_W   = 16;
	localparam int TRIG_W   = 16;
	localparam int WORD_W   = 32;
	localparam int ROT_W    = 28;                // rotated vector, Q.24
	localparam int SUMSQ_W  = 32;
	localparam int RAD_W    = SUMSQ_W + 20;      // radicand, Q.48
	localparam int ROOT_W   = RAD_W / 2;         // radius, Q.24
	localparam int REM_W    = ROOT_W + 2;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [WORD_W-1:0] POS_MAX = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] POS_MIN = 32'h8000_0000;

	localparam logic [WORD_W-1:0] RST_COEF_D  = 32'h0100_0000;
	localparam logic [TRIG_W-1:0] RST_ROT_COS = 16'h7fff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A  = 3'd0,
		REG_COEF_B  = 3'd1,
		REG_COEF_C  = 3'd2,
		REG_COEF_D  = 3'd3,
		REG_ROT_COS = 3'd4,
		REG_ROT_SIN = 3'd5,
		REG_SHIFT_X = 3'd6,
		REG_SHIFT_Y = 3'd7
	} reg_idx_t;

	// rotated vector carried alongside the square root
	typedef struct packed {
		logic signed [ROT_W-1:0] rxq;
		logic signed [ROT_W-1:0] ryq;
	} rot_t;

endpackage

// ----- hdl/gvp_if.sv -----
// Stream interfaces for voltage requests and position results.
interface gvp_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [gvp_pkg::VOLT_W-1:0]     volt_x;
	logic signed [gvp_pkg::VOLT_W-1:0]     volt_y;

	modport source (output valid, output volt_x, output volt_y, input ready);
	modport sink   (input valid, input volt_x, input volt_y, output ready);
endinterface

interface gvp_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [gvp_pkg::WORD_W-1:0]     pos_x;
	logic signed [gvp_pkg::WORD_W-1:0]     pos_y;
	logic                                  saturated;

	modport source (output valid, output pos_x, output pos_y, output saturated, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input saturated, output ready);
endinterface

// ----- hdl/galvo_voltage_to_position.sv -----
// Galvo voltage pair to sample-plane position: rotation, radial polynomial, shift, flip.
//
// Takes one voltage pair per cycle unless the output stalls, and passes it through
// rotation and sum of squares, a square root at one bit per stage, then Horner
// polynomial, scaling, shift and clipping. The whole pipeline moves together: it
// advances whenever the output register is empty or being taken, so a stalled result
// holds every stage in place. Configuration writes take effect on the items accepted
// after them only if the user writes with the pipeline empty; not enforced by the block.
module galvo_voltage_to_position #(
	parameter int FLIP_X = 1,
	parameter int FLIP_Y = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [gvp_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [gvp_pkg::WORD_W-1:0]          cfg_data,
	gvp_in_if.sink                              volt,
	gvp_out_if.source                           pos
);

	logic signed [31:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, shift_x_q, shift_y_q;
	logic signed [15:0] rot_cos_q, rot_sin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q  <= '0;
			coef_b_q  <= '0;
			coef_c_q  <= '0;
			coef_d_q  <= gvp_pkg::RST_COEF_D;
			rot_cos_q <= gvp_pkg::RST_ROT_COS;
			rot_sin_q <= '0;
			shift_x_q <= '0;
			shift_y_q <= '0;
		end else if (cfg_wen) begin
			unique case (gvp_pkg::reg_idx_t'(cfg_idx))
				gvp_pkg::REG_COEF_A:  coef_a_q  <= cfg_data;
				gvp_pkg::REG_COEF_B:  coef_b_q  <= cfg_data;
				gvp_pkg::REG_COEF_C:  coef_c_q  <= cfg_data;
				gvp_pkg::REG_COEF_D:  coef_d_q  <= cfg_data;
				gvp_pkg::REG_ROT_COS: rot_cos_q <= cfg_data[15:0];
				gvp_pkg::REG_ROT_SIN: rot_sin_q <= cfg_data[15:0];
				gvp_pkg::REG_SHIFT_X: shift_x_q <= cfg_data;
				gvp_pkg::REG_SHIFT_Y: shift_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	assign en         = !pos.valid || pos.ready;
	assign volt.ready = en;

	// s1: rotation products and squares
	logic               v_s1;
	logic signed [31:0] p_xc_s1, p_ys_s1, p_xs_s1, p_yc_s1, sq_x_s1, sq_y_s1;
	// s2: rotated vector, radicand
	logic               v_s2;
	gvp_pkg::rot_t      rot_s2;
	logic [gvp_pkg::RAD_W-1:0] rad_s2;
	// after square root
	logic                       v_r;
	logic [gvp_pkg::ROOT_W-1:0] root_r;
	gvp_pkg::rot_t              rot_r;
	// s3..s10: polynomial and scaling
	logic v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	gvp_pkg::rot_t rot_s3, rot_s4, rot_s5, rot_s6, rot_s7, rot_s8;
	logic [gvp_pkg::ROOT_W-1:0] r_s3, r_s4, r_s5, r_s6;
	logic signed [58:0] m1_s3;
	logic signed [34:0] t1_s4;
	logic signed [45:0] ph2_s5;
	logic        [43:0] pl2_s5;
	logic signed [37:0] t2_s6;
	logic signed [48:0] ph3_s7;
	logic        [43:0] pl3_s7;
	logic signed [39:0] f_s8;
	logic signed [47:0] phx_s9, phy_s9;
	logic signed [48:0] plx_s9, ply_s9;
	logic signed [44:0] px_s10, py_s10;

	logic signed [32:0] rx, ry;
	logic [gvp_pkg::SUMSQ_W-1:0] sumsq;
	logic signed [26:0] r3s, r5s, r7s;
	logic signed [63:0] m2, m3;
	logic signed [67:0] prod_x, prod_y;
	logic signed [45:0] fx, fy;
	logic               sat_x, sat_y;
	logic [31:0]        cx, cy;

	always_comb begin
		rx    = 33'(p_xc_s1) - 33'(p_ys_s1);
		ry    = 33'(p_xs_s1) + 33'(p_yc_s1);
		sumsq = gvp_pkg::SUMSQ_W'(sq_x_s1) + gvp_pkg::SUMSQ_W'(sq_y_s1);
		r3s   = $signed({1'b0, root_r});
		r5s   = $signed({1'b0, r_s4});
		r7s   = $signed({1'b0, r_s6});
		m2    = (64'(ph2_s5) <<< 16) + $signed(64'(pl2_s5));
		m3    = (64'(ph3_s7) <<< 16) + $signed(64'(pl3_s7));
		prod_x = (68'(phx_s9) <<< 20) + 68'(plx_s9);
		prod_y = (68'(phy_s9) <<< 20) + 68'(ply_s9);
	end

	// flip, then clip to 32 bits
	always_comb begin
		if (FLIP_X > 0)      fx = 46'(px_s10);
		else if (FLIP_X < 0) fx = -46'(px_s10);
		else                 fx = '0;
		if (FLIP_Y > 0)      fy = 46'(py_s10);
		else if (FLIP_Y < 0) fy = -46'(py_s10);
		else                 fy = '0;
		sat_x = !((&fx[45:31]) || !(|fx[45:31]));
		sat_y = !((&fy[45:31]) || !(|fy[45:31]));
		cx = sat_x ? (fx[45] ? gvp_pkg::POS_MIN : gvp_pkg::POS_MAX) : fx[31:0];
		cy = sat_y ? (fy[45] ? gvp_pkg::POS_MIN : gvp_pkg::POS_MAX) : fy[31:0];
	end

	gvp_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s2),
		.rad     (rad_s2),
		.tag     (rot_s2),
		.out_v   (v_r),
		.root    (root_r),
		.tag_out (rot_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			pos.valid <= 1'b0;
		end else if (en) begin
			v_s1 <= volt.valid; v_s2 <= v_s1; v_s3 <= v_r; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9;
			pos.valid <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_xc_s1 <= volt.volt_x * rot_cos_q;
			p_ys_s1 <= volt.volt_y * rot_sin_q;
			p_xs_s1 <= volt.volt_x * rot_sin_q;
			p_yc_s1 <= volt.volt_y * rot_cos_q;
			sq_x_s1 <= volt.volt_x * volt.volt_x;
			sq_y_s1 <= volt.volt_y * volt.volt_y;

			rot_s2.rxq <= gvp_pkg::ROT_W'(rx >>> 5);
			rot_s2.ryq <= gvp_pkg::ROT_W'(ry >>> 5);
			rad_s2     <= {sumsq, 20'd0};

			m1_s3  <= 59'(coef_a_q * r3s);
			r_s3   <= root_r;
			rot_s3 <= rot_r;

			t1_s4  <= 35'(m1_s3 >>> 24) + 35'(coef_b_q);
			r_s4   <= r_s3;
			rot_s4 <= rot_s3;

			// split t into signed high and unsigned low halves
			ph2_s5 <= 46'($signed(t1_s4[34:16]) * r5s);
			pl2_s5 <= 44'({1'b0, t1_s4[15:0]} * {1'b0, r_s4});
			r_s5   <= r_s4;
			rot_s5 <= rot_s4;

			t2_s6  <= 38'(m2 >>> 24) + 38'(coef_c_q);
			r_s6   <= r_s5;
			rot_s6 <= rot_s5;

			ph3_s7 <= 49'($signed(t2_s6[37:16]) * r7s);
			pl3_s7 <= 44'({1'b0, t2_s6[15:0]} * {1'b0, r_s6});
			rot_s7 <= rot_s6;

			f_s8   <= 40'(m3 >>> 24) + 40'(coef_d_q);
			rot_s8 <= rot_s7;

			phx_s9 <= 48'(rot_s8.rxq * $signed(f_s8[39:20]));
			plx_s9 <= 49'(rot_s8.rxq * $signed({1'b0, f_s8[19:0]}));
			phy_s9 <= 48'(rot_s8.ryq * $signed(f_s8[39:20]));
			ply_s9 <= 49'(rot_s8.ryq * $signed({1'b0, f_s8[19:0]}));

			px_s10 <= 45'(prod_x >>> 24) + 45'(shift_x_q);
			py_s10 <= 45'(prod_y >>> 24) + 45'(shift_y_q);

			pos.pos_x     <= cx;
			pos.pos_y     <= cy;
			pos.saturated <= sat_x || sat_y;
		end
	end

endmodule

// ----- hdl/gvp_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module gvp_isqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_v,
	input  logic [gvp_pkg::RAD_W-1:0]       rad,
	input  gvp_pkg::rot_t                   tag,
	output logic                            out_v,
	output logic [gvp_pkg::ROOT_W-1:0]      root,
	output gvp_pkg::rot_t                   tag_out
);

	localparam int N = gvp_pkg::SQRT_STAGES;

	logic [gvp_pkg::REM_W-1:0]  rem_s  [N];
	logic [gvp_pkg::ROOT_W-1:0] root_s [N];
	logic [gvp_pkg::RAD_W-1:0]  rad_s  [N];
	logic                       v_s    [N];
	gvp_pkg::rot_t              tag_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [gvp_pkg::REM_W-1:0]  rem_in;
		logic [gvp_pkg::ROOT_W-1:0] root_in;
		logic [gvp_pkg::RAD_W-1:0]  rad_in;
		logic                       v_in;
		gvp_pkg::rot_t              tag_in;
		logic [gvp_pkg::REM_W+1:0]  cur;
		logic [gvp_pkg::REM_W+1:0]  test;
		logic [gvp_pkg::REM_W-1:0]  rem_nx;
		logic [gvp_pkg::ROOT_W-1:0] root_nx;

		if (k == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign v_in    = in_v;
			assign tag_in  = tag;
		end else begin : g_body
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign v_in    = v_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		// bring down two radicand bits, try root*4+1
		always_comb begin
			cur  = {rem_in, rad_in[gvp_pkg::RAD_W-1 -: 2]};
			test = {gvp_pkg::REM_W'(root_in), 2'b01};
			if (cur >= test) begin
				rem_nx  = gvp_pkg::REM_W'(cur - test);
				root_nx = {root_in[gvp_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx  = gvp_pkg::REM_W'(cur);
				root_nx = {root_in[gvp_pkg::ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nx;
				root_s[k] <= root_nx;
				rad_s[k]  <= rad_in << 2;
				tag_s[k]  <= tag_in;
			end
		end
	end

	assign out_v   = v_s[N-1];
	assign root    = root_s[N-1];
	assign tag_out = tag_s[N-1];

endmodule

// ----- hdl/gvp_checker.sv -----
// Port-level checks for the galvo voltage to position block, with its bind.
`include "assert_macros.svh"

module gvp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pos_x,
	input logic [31:0] pos_y,
	input logic        saturated
);

	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(saturated), "stalled result changed")
	`ASSERT_CLK(a_ready_free, !out_valid |-> in_ready, "request refused with empty output")
	`ASSERT_CLK(a_sat_rail, out_valid && saturated |-> pos_x == 32'h7fffffff || pos_x == 32'h80000000 || pos_y == 32'h7fffffff || pos_y == 32'h80000000, "saturation flag without a clipped position")
	// output register is cleared asynchronously while in reset
	`ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !out_valid, "result valid in reset")

endmodule

bind galvo_voltage_to_position gvp_checker u_gvp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (volt.ready),
	.out_valid (pos.valid),
	.out_ready (pos.ready),
	.pos_x     (pos.pos_x),
	.pos_y     (pos.pos_y),
	.saturated (pos.saturated)
);

// ----- bench/galvo_voltage_to_position_tb.sv -----
// Self-checking bench for the galvo voltage to position block.
module galvo_voltage_to_position_tb;

	localparam int FLIP_X = 1;
	localparam int FLIP_Y = 1;
	localparam int PIPE_LAT = 37;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic signed [gvp_pkg::WORD_W-1:0] px;
		logic signed [gvp_pkg::WORD_W-1:0] py;
		logic                              sat;
	} position_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [gvp_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [gvp_pkg::WORD_W-1:0] cfg_data = '0;

	gvp_in_if  volt_bus ();
	gvp_out_if pos_bus ();

	galvo_voltage_to_position #(.FLIP_X(FLIP_X), .FLIP_Y(FLIP_Y)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .volt(volt_bus), .pos(pos_bus)
	);

	always #5 clk = ~clk;

	// shadow copy of the calibration registers
	logic signed [gvp_pkg::WORD_W-1:0] sh_a, sh_b, sh_c, sh_d, sh_tx, sh_ty;
	logic signed [gvp_pkg::TRIG_W-1:0] sh_cos, sh_sin;

	position_t pending_pos[$];
	int n_sent = 0, n_checked = 0, n_errors = 0, n_cfg = 0, n_sat = 0;
	int idle_cycles = 0;
	int hold_off = 0;     // long receiver stall requested by the pressure test
	bit steady = 1'b0;    // no idling on either side

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint flip_clip(longint p, int flip, ref logic sat);
		longint q;
		q = (flip > 0) ? p : (flip < 0) ? -p : 0;
		if (q > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (q < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return q;
	endfunction

	function automatic position_t predict_position(logic signed [gvp_pkg::VOLT_W-1:0] vx,
			logic signed [gvp_pkg::VOLT_W-1:0] vy);
		position_t r;
		longint x, y, cs, sn, rxq, ryq, rad, f, px, py;
		logic sat;
		x = vx; y = vy; cs = sh_cos; sn = sh_sin;
		rxq = (x * cs - y * sn) >>> 5;
		ryq = (x * sn + y * cs) >>> 5;
		rad = longint'(root_floor(longint'(x * x + y * y) << 20));
		f = sh_a;
		f = ((f * rad) >>> 24) + longint'(sh_b);
		f = ((f * rad) >>> 24) + longint'(sh_c);
		f = ((f * rad) >>> 24) + longint'(sh_d);
		px = ((rxq * f) >>> 24) + longint'(sh_tx);
		py = ((ryq * f) >>> 24) + longint'(sh_ty);
		sat = 1'b0;
		px = flip_clip(px, FLIP_X, sat);
		py = flip_clip(py, FLIP_Y, sat);
		r.px = px[gvp_pkg::WORD_W-1:0];
		r.py = py[gvp_pkg::WORD_W-1:0];
		r.sat = sat;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_volt(logic [gvp_pkg::VOLT_W-1:0] vx, logic [gvp_pkg::VOLT_W-1:0] vy);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			volt_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		volt_bus.valid <= 1'b1;
		volt_bus.volt_x <= vx;
		volt_bus.volt_y <= vy;
		do @(posedge clk); while (!volt_bus.ready);
		pending_pos.insert(pending_pos.size(), predict_position(vx, vy));
		n_sent++;
	endtask

	// registers change only with the pipeline drained
	task automatic write_reg(gvp_pkg::reg_idx_t idx, logic [gvp_pkg::WORD_W-1:0] data);
		@(negedge clk);
		volt_bus.valid <= 1'b0;
		wait (pending_pos.size() == 0);
		repeat (PIPE_LAT + 3) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			gvp_pkg::REG_COEF_A:  sh_a = data;
			gvp_pkg::REG_COEF_B:  sh_b = data;
			gvp_pkg::REG_COEF_C:  sh_c = data;
			gvp_pkg::REG_COEF_D:  sh_d = data;
			gvp_pkg::REG_ROT_COS: sh_cos = data[gvp_pkg::TRIG_W-1:0];
			gvp_pkg::REG_ROT_SIN: sh_sin = data[gvp_pkg::TRIG_W-1:0];
			gvp_pkg::REG_SHIFT_X: sh_tx = data;
			default:              sh_ty = data;
		endcase
		n_cfg++;
	endtask

	task automatic load_config(logic [gvp_pkg::WORD_W-1:0] a, logic [gvp_pkg::WORD_W-1:0] b,
			logic [gvp_pkg::WORD_W-1:0] c, logic [gvp_pkg::WORD_W-1:0] d,
			logic [gvp_pkg::WORD_W-1:0] cs, logic [gvp_pkg::WORD_W-1:0] sn,
			logic [gvp_pkg::WORD_W-1:0] tx, logic [gvp_pkg::WORD_W-1:0] ty);
		write_reg(gvp_pkg::REG_COEF_A, a);
		write_reg(gvp_pkg::REG_COEF_B, b);
		write_reg(gvp_pkg::REG_COEF_C, c);
		write_reg(gvp_pkg::REG_COEF_D, d);
		write_reg(gvp_pkg::REG_ROT_COS, cs);
		write_reg(gvp_pkg::REG_ROT_SIN, sn);
		write_reg(gvp_pkg::REG_SHIFT_X, tx);
		write_reg(gvp_pkg::REG_SHIFT_Y, ty);
	endtask

	task automatic send_corners();
		send_volt(16'h8000, 16'h8000);
		send_volt(16'h7fff, 16'h7fff);
		send_volt(16'h8000, 16'h7fff);
		send_volt(16'h7fff, 16'h8000);
		send_volt(16'h0000, 16'h0000);
		send_volt(16'h4000, 16'h0000);
		send_volt(16'h0000, 16'hc000);
		send_volt(16'hffff, 16'h0001);
	endtask

	// reset values, then a rotation with a shift and no radial terms, then saturating coefficients
	task automatic test_directed();
		send_corners();
		load_config(32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0000_5a82, 32'h0000_5a82,
			32'h1234_5678, 32'h8765_4321);
		send_corners();
		load_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_8000, 32'h0000_8000, 32'h7fff_ffff, 32'h8000_0000);
		send_corners();
	endtask

	task automatic random_config();
		if ($urandom_range(0, 3) == 0) begin
			load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end else begin
			// moderate distortion so most results stay in range
			load_config(32'($signed($urandom_range(0, 1 << 16)) - (1 << 15)),
				32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
				32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)),
				32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)),
				$urandom, $urandom,
				32'($signed($urandom_range(0, 1 << 28)) - (1 << 27)),
				32'($signed($urandom_range(0, 1 << 28)) - (1 << 27)));
		end
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 8; phase++) begin
			random_config();
			steady = (phase == 3);
			for (int i = 0; i < 110; i++) send_volt($urandom, $urandom);
			steady = 1'b0;
		end
	endtask

	// receiver stalls long while the sender keeps offering back to back
	task automatic test_backpressure();
		random_config();
		steady = 1'b1;
		hold_off = 300;
		for (int i = 0; i < 120; i++) send_volt($urandom, $urandom);
		steady = 1'b0;
	endtask

	// receiver readiness
	int stall_left = 0;
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			pos_bus.ready <= 1'b0;
		end else if (steady) begin
			pos_bus.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pos_bus.ready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			pos_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		position_t want;
		if (pos_bus.valid && pos_bus.ready) begin
			if (pending_pos.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("ERROR: position with no request outstanding");
			end else begin
				want = pending_pos.pop_front();
				n_checked++;
				if (want.sat) n_sat++;
				if (pos_bus.pos_x !== want.px || pos_bus.pos_y !== want.py ||
						pos_bus.saturated !== want.sat) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: result %0d exp x=%h y=%h sat=%b got x=%h y=%h sat=%b",
							n_checked, want.px, want.py, want.sat,
							pos_bus.pos_x, pos_bus.pos_y, pos_bus.saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((volt_bus.valid && volt_bus.ready) || (pos_bus.valid && pos_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no progress, %0d results outstanding", pending_pos.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		volt_bus.valid = 1'b0;
		volt_bus.volt_x = '0;
		volt_bus.volt_y = '0;
		pos_bus.ready = 1'b0;
		sh_a = '0; sh_b = '0; sh_c = '0; sh_d = gvp_pkg::RST_COEF_D;
		sh_cos = gvp_pkg::RST_ROT_COS; sh_sin = '0; sh_tx = '0; sh_ty = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		test_backpressure();
		@(negedge clk);
		volt_bus.valid <= 1'b0;
		wait (pending_pos.size() == 0);
		repeat (PIPE_LAT + 10) @(posedge clk);
		$display("Covered %0d voltage requests, %0d results checked (%0d saturated),",
			n_sent, n_checked, n_sat);
		$display("%0d register writes incl. extremes, one long output stall; %0d mismatches",
			n_cfg, n_errors);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
